### sv/fpbq_pkg.sv
// ----------------------------------------------------------------------------
// fpbq_pkg
// Shared constants and the rounding product helper for the biquad filter.
// ----------------------------------------------------------------------------
`default_nettype none

package fpbq_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned CfgIdxWidth = 3;

  typedef logic signed [SampleWidth-1:0] sample_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_B0       = 3'd0,
    REG_B1       = 3'd1,
    REG_B2       = 3'd2,
    REG_A1       = 3'd3,
    REG_A2       = 3'd4,
    REG_INIT_IN  = 3'd5,
    REG_INIT_OUT = 3'd6
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam sample_t RstB0      = 16'sh76B0;
  localparam sample_t RstB1      = 16'sh76B0;
  localparam sample_t RstB2      = 16'sh76B0;
  localparam sample_t RstA1      = 16'sh74A7;
  localparam sample_t RstA2      = 16'sh94D7;
  localparam sample_t RstInitIn  = 16'sh8001;
  localparam sample_t RstInitOut = 16'shC000;

  // Right shifts applied to each product
  localparam int unsigned ShB0 = 24;
  localparam int unsigned ShB1 = 23;
  localparam int unsigned ShB2 = 24;
  localparam int unsigned ShA1 = 14;
  localparam int unsigned ShA2 = 15;

  // Signed 16x16 product, rounded and arithmetic-shifted right by sh.
  // Only the low 16 bits are kept: the final sum wraps modulo 2^16 anyway.
  function automatic logic [SampleWidth-1:0] rnd_prod(
    input sample_t     coef,
    input sample_t     data,
    input int unsigned sh
  );
    logic signed [31:0] prod;
    logic signed [32:0] acc;
    logic signed [32:0] shifted;
    prod    = coef * data;
    acc     = 33'(prod) + (33'sd1 <<< (sh - 1));
    shifted = acc >>> sh;
    return shifted[SampleWidth-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/fixed_point_biquad_iir.sv
// ----------------------------------------------------------------------------
// fixed_point_biquad_iir
// Second-order direct-form-I IIR filter on signed 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_valid/in_ready/sample_in and are captured in an
//   input register. From there the five products, their rounding and the
//   wrapped sum are formed and the result lands in the output register, which
//   drives out_valid/sample_out. One word per cycle is sustained while the
//   output is not stalled: the input register advances whenever the output
//   register is empty or being drained, and the past-output registers that
//   feed the sum back update on each such advance.
//   If the receiver holds out_ready low, the output register keeps its word,
//   the input register fills, and in_ready drops until the output drains.
//   The configuration channel is always ready; a write to index 0..6 updates
//   that register and reloads both past inputs and both past outputs from
//   initial_input and initial_output. Writes to index 7 are ignored.
//   Configuration must be written only while the filter is idle; not enforced.
//   Reset (rst, synchronous) restores the default coefficients, loads the
//   past values from the default initial conditions and empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_biquad_iir
  import fpbq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // sample input
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic signed [15:0]     sample_in,
  // sample output
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [15:0]          sample_out,
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CfgIdxWidth-1:0] cfg_index,
  input  wire logic signed [15:0]     cfg_data
);

  // Configuration registers
  sample_t coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  sample_t initial_input, initial_output;
  sample_t coef_b0_next, coef_b1_next, coef_b2_next, coef_a1_next, coef_a2_next;
  sample_t initial_input_next, initial_output_next;
  logic    cfg_hit;

  // Filter history
  sample_t past_in_one, past_in_two, past_out_one, past_out_two;

  // Input stage and output stage
  logic    x_valid;
  sample_t x_data;
  sample_t y_data;
  logic    advance;
  logic    in_fire;

  assign cfg_ready = 1'b1;

  // Output register frees up when empty or taken this cycle
  assign advance  = x_valid && (!out_valid || out_ready);
  assign in_ready = !x_valid || advance;
  assign in_fire  = in_valid && in_ready;

  // Register write decode
  always_comb begin
    coef_b0_next        = coef_b0;
    coef_b1_next        = coef_b1;
    coef_b2_next        = coef_b2;
    coef_a1_next        = coef_a1;
    coef_a2_next        = coef_a2;
    initial_input_next  = initial_input;
    initial_output_next = initial_output;
    cfg_hit             = 1'b0;
    if (cfg_valid) begin
      cfg_hit = 1'b1;
      case (cfg_reg_t'(cfg_index))
        REG_B0:       coef_b0_next        = cfg_data;
        REG_B1:       coef_b1_next        = cfg_data;
        REG_B2:       coef_b2_next        = cfg_data;
        REG_A1:       coef_a1_next        = cfg_data;
        REG_A2:       coef_a2_next        = cfg_data;
        REG_INIT_IN:  initial_input_next  = cfg_data;
        REG_INIT_OUT: initial_output_next = cfg_data;
        default:      cfg_hit             = 1'b0;
      endcase
    end
  end

  // Five rounded products summed modulo 2^16
  always_comb begin
    y_data = sample_t'(rnd_prod(coef_b0, x_data, ShB0)
                     + rnd_prod(coef_b1, past_in_one, ShB1)
                     + rnd_prod(coef_b2, past_in_two, ShB2)
                     + rnd_prod(coef_a1, past_out_one, ShA1)
                     + rnd_prod(coef_a2, past_out_two, ShA2));
  end

  // Configuration and history
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0        <= RstB0;
      coef_b1        <= RstB1;
      coef_b2        <= RstB2;
      coef_a1        <= RstA1;
      coef_a2        <= RstA2;
      initial_input  <= RstInitIn;
      initial_output <= RstInitOut;
      past_in_one    <= RstInitIn;
      past_in_two    <= RstInitIn;
      past_out_one   <= RstInitOut;
      past_out_two   <= RstInitOut;
    end else if (cfg_hit) begin
      coef_b0        <= coef_b0_next;
      coef_b1        <= coef_b1_next;
      coef_b2        <= coef_b2_next;
      coef_a1        <= coef_a1_next;
      coef_a2        <= coef_a2_next;
      initial_input  <= initial_input_next;
      initial_output <= initial_output_next;
      past_in_one    <= initial_input_next;
      past_in_two    <= initial_input_next;
      past_out_one   <= initial_output_next;
      past_out_two   <= initial_output_next;
    end else if (advance) begin
      past_in_two  <= past_in_one;
      past_in_one  <= x_data;
      past_out_two <= past_out_one;
      past_out_one <= y_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
    end else if (in_fire) begin
      x_valid <= 1'b1;
    end else if (advance) begin
      x_valid <= 1'b0;
    end
    if (in_fire) begin
      x_data <= sample_in;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      sample_out <= y_data;
    end
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-point biquad filter. A scoreboard keeps
// its own copy of the coefficients and of the filter history. It predicts
// each output word when an input word is taken, and then matches the output
// stream in order. Coefficients are set between bursts of samples: first the
// directed corners, then random settings with random idle and stall bursts.
// ----------------------------------------------------------------------------

module tb_top;
  import fpbq_pkg::*;

  localparam logic [CfgIdxWidth-1:0] RegUnused = 3'd7;  // no register here
  localparam int StallLimit = 4000;
  localparam int RandomWords = 1880;

  logic clk;
  logic rst = 1'b1;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [15:0]     sample_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [15:0]     sample_out;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic signed [15:0]     cfg_data = '0;

  fixed_point_biquad_iir uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Words waiting to be sent, and filter outputs waiting to come back
  logic signed [15:0] sample_queue[$];
  logic signed [15:0] expected_samples[$];

  // Scoreboard copy of the coefficients and the filter history
  logic signed [15:0] coef_cfg[0:6];
  logic signed [15:0] hist_x1, hist_x2, hist_y1, hist_y2;

  logic in_taken = 1'b0;
  int   in_idle_pct = 0;
  int   out_idle_pct = 0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   error_count = 0;
  int   out_words = 0;
  int   stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Product of coefficient and sample, rounded and shifted right by sh
  function automatic logic signed [31:0] scaled_product(logic signed [15:0] c,
                                                        logic signed [15:0] d,
                                                        int unsigned sh);
    logic signed [63:0] p;
    p = c * d;
    p = p + (64'sd1 <<< (sh - 1));
    p = p >>> sh;
    return p[31:0];
  endfunction

  // Mostly full-range words, with corners and near-zero values mixed in
  function automatic logic signed [15:0] random_word();
    logic signed [15:0] w;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: w = 16'sh7FFF;
          1: w = 16'sh8000;
          2: w = 16'sh0000;
          3: w = 16'shFFFF;
          default: w = 16'sh0001;
        endcase
      end
      1: w = 16'($signed($urandom_range(0, 64)) - 32);
      default: w = 16'($urandom);
    endcase
    return w;
  endfunction

  task automatic report(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endtask

  // Input driver: holds each word until taken, idles in random bursts
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (sample_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(0, 99) < in_idle_pct) begin
        in_gap = $urandom_range(1, 19) - 1;
        in_valid <= 1'b0;
      end else begin
        sample_in <= sample_queue.pop_front();
        in_valid  <= 1'b1;
      end
    end
  end

  // Output back-pressure in random bursts
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (!rst && $urandom_range(0, 99) < out_idle_pct) begin
      out_gap = $urandom_range(1, 19) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: tracks register writes, predicts on input, checks output
  always @(posedge clk) begin
    logic signed [31:0] acc;
    logic signed [15:0] want;
    if (rst) begin
      coef_cfg[REG_B0]       = RstB0;
      coef_cfg[REG_B1]       = RstB1;
      coef_cfg[REG_B2]       = RstB2;
      coef_cfg[REG_A1]       = RstA1;
      coef_cfg[REG_A2]       = RstA2;
      coef_cfg[REG_INIT_IN]  = RstInitIn;
      coef_cfg[REG_INIT_OUT] = RstInitOut;
      hist_x1 = RstInitIn;
      hist_x2 = RstInitIn;
      hist_y1 = RstInitOut;
      hist_y2 = RstInitOut;
      in_taken <= 1'b0;
    end else begin
      // a write to a real register reloads the whole history
      if (cfg_valid && cfg_ready && cfg_index <= REG_INIT_OUT) begin
        coef_cfg[cfg_index] = cfg_data;
        hist_x1 = coef_cfg[REG_INIT_IN];
        hist_x2 = coef_cfg[REG_INIT_IN];
        hist_y1 = coef_cfg[REG_INIT_OUT];
        hist_y2 = coef_cfg[REG_INIT_OUT];
      end

      // filter step; the wrapped output is what feeds back
      if (in_valid && in_ready) begin
        acc = scaled_product(coef_cfg[REG_B0], sample_in, ShB0)
            + scaled_product(coef_cfg[REG_B1], hist_x1, ShB1)
            + scaled_product(coef_cfg[REG_B2], hist_x2, ShB2)
            + scaled_product(coef_cfg[REG_A1], hist_y1, ShA1)
            + scaled_product(coef_cfg[REG_A2], hist_y2, ShA2);
        want = acc[15:0];
        expected_samples.push_back(want);
        hist_x2 = hist_x1;
        hist_x1 = sample_in;
        hist_y2 = hist_y1;
        hist_y1 = want;
      end
      in_taken <= in_valid && in_ready;

      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report($sformatf("word %0d: unexpected sample_out %0d", out_words, sample_out));
        end else begin
          want = expected_samples.pop_front();
          if (sample_out !== want)
            report($sformatf("word %0d: sample_out expected %0d got %0d",
                             out_words, want, sample_out));
        end
        out_words++;
      end

      // watchdog on a stalled stream
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic signed [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every queued word has gone through the filter
  task automatic drain();
    while (sample_queue.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_all(input logic signed [15:0] coef, input logic signed [15:0] init);
    write_reg(REG_B0, coef);
    write_reg(REG_B1, coef);
    write_reg(REG_B2, coef);
    write_reg(REG_A1, coef);
    write_reg(REG_A2, coef);
    write_reg(REG_INIT_IN, init);
    write_reg(REG_INIT_OUT, init);
    end_writes();
  endtask

  initial begin
    int remaining;
    int n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset coefficients with extreme and patterned samples
    in_idle_pct  = 20;
    out_idle_pct = 20;
    sample_queue = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0000,
                     16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA};
    drain();

    // write to the unused index: no reload, history carries on
    write_reg(RegUnused, 16'sh1234);
    end_writes();
    sample_queue.push_back(16'sd12345);
    drain();

    // largest coefficients and history: sum overflows and wraps
    write_all(16'sh7FFF, 16'sh7FFF);
    sample_queue = '{16'sh7FFF, 16'sh8000, 16'sh7FFF};
    drain();

    // most negative everywhere
    write_all(16'sh8000, 16'sh8000);
    sample_queue = '{16'sh8000, 16'sh7FFF, 16'sh8000};
    drain();

    // pure feedback path from the history
    write_all(16'sh0000, 16'sh4000);
    write_reg(REG_A1, 16'sh7FFF);
    write_reg(REG_A2, 16'sh8000);
    end_writes();
    sample_queue = '{16'sh0000, 16'sh0000, 16'sh0000};
    drain();

    // Random settings and random sample bursts
    remaining = RandomWords;
    while (remaining > 0) begin
      for (int r = REG_B0; r <= REG_INIT_OUT; r++)
        if ($urandom_range(0, 3) != 0) write_reg(r[CfgIdxWidth-1:0], random_word());
      if ($urandom_range(0, 4) == 0) write_reg(RegUnused, random_word());
      end_writes();

      if (remaining <= 150) begin
        n = remaining;
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        n = $urandom_range(60, 200);
        if (n > remaining - 150) n = remaining - 150;
        case ($urandom_range(0, 3))
          0: in_idle_pct = 0;
          1: in_idle_pct = 5;
          2: in_idle_pct = 20;
          default: in_idle_pct = 50;
        endcase
        case ($urandom_range(0, 3))
          0: out_idle_pct = 0;
          1: out_idle_pct = 5;
          2: out_idle_pct = 20;
          default: out_idle_pct = 50;
        endcase
      end
      for (int i = 0; i < n; i++) sample_queue.push_back(random_word());
      remaining -= n;
      drain();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_samples.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
